FILE: rtl/wkf_pkg.sv
// Package for the 2-D window kernel filter: sizes, reset values and register map.
// Used by the channel interfaces and by the top level; it depends on nothing.
`timescale 1ns / 1ps

package wkf_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DEF_MAX_COLS   = 1024;
   localparam int DEF_MAX_ROWS   = 1024;
   localparam int DEF_PIXEL_BITS = 16;

   // Fixed field widths.
   localparam int SIZE_BITS     = 11;
   localparam int TAP_BITS      = 16;
   localparam int FILTERED_BITS = 36;
   localparam int POS_BITS      = 10;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // Register reset values.
   localparam logic [SIZE_BITS-1:0]       RST_WIDTH        = 11'd12;
   localparam logic [SIZE_BITS-1:0]       RST_HEIGHT       = 11'd12;
   localparam logic signed [TAP_BITS-1:0] RST_TAP_TOP_LEFT = 16'sd1;
   localparam logic signed [TAP_BITS-1:0] RST_TAP_TOP_RGHT = -16'sd1;
   localparam logic signed [TAP_BITS-1:0] RST_TAP_BOT_LEFT = -16'sd1;
   localparam logic signed [TAP_BITS-1:0] RST_TAP_BOT_RGHT = 16'sd1;

   // Register indexes (byte address is four times the index).
   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH      = 3'd0,
      REG_IMAGE_HEIGHT     = 3'd1,
      REG_TAP_TOP_LEFT     = 3'd2,
      REG_TAP_TOP_RIGHT    = 3'd3,
      REG_TAP_BOTTOM_LEFT  = 3'd4,
      REG_TAP_BOTTOM_RIGHT = 3'd5
   } csr_index_type;

endpackage

FILE: rtl/wkf_if.sv
// Valid/ready channel interfaces for the pixel input and the filtered output.
// Depends on wkf_pkg for the fixed field widths.
`timescale 1ns / 1ps

interface wkf_req_if #(
   parameter int PIXEL_BITS = wkf_pkg::DEF_PIXEL_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] pixel;
   logic                         frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface wkf_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [wkf_pkg::FILTERED_BITS-1:0] filtered;
   logic [wkf_pkg::POS_BITS-1:0]             out_row;
   logic [wkf_pkg::POS_BITS-1:0]             out_col;
   logic                                      frame_last;

   modport source (output valid, output filtered, output out_row, output out_col,
                   output frame_last, input ready);
   modport sink   (input valid, input filtered, input out_row, input out_col,
                   input frame_last, output ready);
endinterface

FILE: rtl/window_kernel_filter_2d_top.sv
// Top level of the 2-D window kernel filter: line stores, window, kernel pipeline, CSRs.
// Depends on wkf_pkg and on the channel interfaces in wkf_if.sv.
//
//   Channel    Direction  Handshake              Carries
//   req_port   in         valid / ready          pixel, frame_start
//   rsp_port   out        valid / ready          filtered, out_row, out_col, frame_last
//   APB        in         psel/penable/pready    six 32-bit registers at 4*index
//
// One pixel is accepted per cycle while stage 1 is free and no clearing pass runs; the rate
// is set by the single read port of each line store, read once per pixel at the pixel's column.
// A pixel's result is registered in turn in the input, block-sum, product and result stages.
// After reset both line stores are zeroed, one column per cycle, over all MAX_COLS columns;
// no pixel is taken during that pass, while register writes are accepted.
// Each stage moves on when the stage after it is empty or moving, so a stalled result
// only holds the pipeline once every stage behind it is occupied.
`timescale 1ns / 1ps

module window_kernel_filter_2d_top #(
   parameter int MAX_COLS   = wkf_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = wkf_pkg::DEF_MAX_ROWS,
   parameter int PIXEL_BITS = wkf_pkg::DEF_PIXEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   wkf_req_if.sink                             req_port,
   wkf_rsp_if.source                           rsp_port,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wkf_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [wkf_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [wkf_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int WW    = $clog2(MAX_COLS + 1);
   localparam int HW    = $clog2(MAX_ROWS + 1);
   localparam int SZW   = wkf_pkg::SIZE_BITS;
   localparam int CmpCW = ((SZW > WW) ? SZW : WW) + 1;
   localparam int CmpRW = ((SZW > HW) ? SZW : HW) + 1;
   localparam int SW    = PIXEL_BITS + 2;
   localparam int PW    = SW + wkf_pkg::TAP_BITS;
   localparam int AccW  = (PW + 3 > wkf_pkg::FILTERED_BITS) ? PW + 3 : wkf_pkg::FILTERED_BITS;
   localparam int PosW  = wkf_pkg::POS_BITS;
   localparam int TW    = wkf_pkg::TAP_BITS;
   localparam int FW    = wkf_pkg::FILTERED_BITS;

   // ---------------------------------------------------------------- registers
   logic [SZW-1:0]       width_ff, height_ff;
   logic signed [TW-1:0] tap_ff [4];
   wkf_pkg::csr_index_type csr_idx;
   logic                 csr_write;

   assign pready    = 1'b1;
   assign csr_idx   = wkf_pkg::csr_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   // Register writes complete in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= wkf_pkg::RST_WIDTH;
         height_ff <= wkf_pkg::RST_HEIGHT;
         tap_ff[0] <= wkf_pkg::RST_TAP_TOP_LEFT;
         tap_ff[1] <= wkf_pkg::RST_TAP_TOP_RGHT;
         tap_ff[2] <= wkf_pkg::RST_TAP_BOT_LEFT;
         tap_ff[3] <= wkf_pkg::RST_TAP_BOT_RGHT;
      end else if (csr_write) begin
         case (csr_idx)
            wkf_pkg::REG_IMAGE_WIDTH:      width_ff  <= pwdata[SZW-1:0];
            wkf_pkg::REG_IMAGE_HEIGHT:     height_ff <= pwdata[SZW-1:0];
            wkf_pkg::REG_TAP_TOP_LEFT:     tap_ff[0] <= pwdata[TW-1:0];
            wkf_pkg::REG_TAP_TOP_RIGHT:    tap_ff[1] <= pwdata[TW-1:0];
            wkf_pkg::REG_TAP_BOTTOM_LEFT:  tap_ff[2] <= pwdata[TW-1:0];
            wkf_pkg::REG_TAP_BOTTOM_RIGHT: tap_ff[3] <= pwdata[TW-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_idx)
         wkf_pkg::REG_IMAGE_WIDTH:      prdata = 32'(width_ff);
         wkf_pkg::REG_IMAGE_HEIGHT:     prdata = 32'(height_ff);
         wkf_pkg::REG_TAP_TOP_LEFT:     prdata = 32'(unsigned'(tap_ff[0]));
         wkf_pkg::REG_TAP_TOP_RIGHT:    prdata = 32'(unsigned'(tap_ff[1]));
         wkf_pkg::REG_TAP_BOTTOM_LEFT:  prdata = 32'(unsigned'(tap_ff[2]));
         wkf_pkg::REG_TAP_BOTTOM_RIGHT: prdata = 32'(unsigned'(tap_ff[3]));
         default:                       prdata = '0;
      endcase
   end

   // Frame size clamped to the range the line stores support.
   logic [CmpCW-1:0] w_cl;
   logic [CmpRW-1:0] h_cl;

   always_comb begin
      if (CmpCW'(width_ff) < CmpCW'(3))              w_cl = CmpCW'(3);
      else if (CmpCW'(width_ff) > CmpCW'(MAX_COLS))  w_cl = CmpCW'(MAX_COLS);
      else                                           w_cl = CmpCW'(width_ff);
      if (CmpRW'(height_ff) < CmpRW'(3))             h_cl = CmpRW'(3);
      else if (CmpRW'(height_ff) > CmpRW'(MAX_ROWS)) h_cl = CmpRW'(MAX_ROWS);
      else                                           h_cl = CmpRW'(height_ff);
   end

   // ---------------------------------------------------------------- control
   logic          clearing_ff;
   logic [CW-1:0] clr_addr_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic           v1_ff, v2_ff, v3_ff, ov_ff;
   logic           en_out, en3, en2, s1_leave, s1_free, accept;

   logic [CW-1:0]  c_a, c_b;
   logic [RW-1:0]  r_a, r_c;
   logic [RW:0]    r_b, r_n;
   logic [CW:0]    c_n;
   logic           wrap_in, wrap_out, pos_produce, pos_last;

   // Position of the arriving pixel and of the one after it.
   assign c_a      = req_port.frame_start ? '0 : col_ff;
   assign r_a      = req_port.frame_start ? '0 : row_ff;
   assign wrap_in  = CmpCW'(c_a) >= w_cl;
   assign c_b      = wrap_in ? '0 : c_a;
   assign r_b      = (RW+1)'(r_a) + (RW+1)'(wrap_in);
   assign r_c      = (CmpRW'(r_b) >= h_cl) ? '0 : r_b[RW-1:0];
   assign c_n      = (CW+1)'(c_b) + (CW+1)'(1);
   assign r_n      = (RW+1)'(r_c) + (RW+1)'(1);
   assign wrap_out = CmpCW'(c_n) >= w_cl;
   assign col_in   = wrap_out ? '0 : c_n[CW-1:0];
   assign row_in   = !wrap_out ? r_c :
                     ((CmpRW'(r_n) >= h_cl) ? '0 : r_n[RW-1:0]);
   assign pos_produce = (r_c >= RW'(2)) && (c_b >= CW'(2));
   assign pos_last    = (CmpRW'(r_c) == h_cl - CmpRW'(1)) &&
                        (CmpCW'(c_b) == w_cl - CmpCW'(1));

   // Stage advance chain: a stage moves when the next one is empty or moving.
   logic prod1_ff;
   assign en_out   = !ov_ff || rsp_port.ready;
   assign en3      = !v3_ff || en_out;
   assign en2      = !v2_ff || en3;
   assign s1_leave = v1_ff && (en2 || !prod1_ff);
   assign s1_free  = !v1_ff || s1_leave;
   assign req_port.ready = s1_free && !clearing_ff;
   assign accept   = req_port.valid && req_port.ready;

   // Line store clearing pass after reset, and the position counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         if (clearing_ff) begin
            if (clr_addr_ff == CW'(MAX_COLS - 1)) clearing_ff <= 1'b0;
            else                                  clr_addr_ff <= clr_addr_ff + CW'(1);
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic signed [PIXEL_BITS-1:0] px1_ff, rdo_ff, rdn_ff, fwdo_ff, fwdn_ff;
   logic signed [PIXEL_BITS-1:0] older1, newer1;
   logic [CW-1:0]                c1_ff;
   logic [RW-1:0]                r1_ff;
   logic                         last1_ff, fwd_ff;

   logic signed [PIXEL_BITS-1:0] mem_older [MAX_COLS];
   logic signed [PIXEL_BITS-1:0] mem_newer [MAX_COLS];
   logic                         mem_we;
   logic [CW-1:0]                mem_waddr;
   logic signed [PIXEL_BITS-1:0] mem_wd_older, mem_wd_newer;

   // A pixel leaving stage 1 in the same cycle that one enters at its column
   // has not yet reached the store, so its values are forwarded.
   assign older1 = fwd_ff ? fwdo_ff : rdo_ff;
   assign newer1 = fwd_ff ? fwdn_ff : rdn_ff;

   assign mem_we       = clearing_ff || s1_leave;
   assign mem_waddr    = clearing_ff ? clr_addr_ff : c1_ff;
   assign mem_wd_older = clearing_ff ? '0 : newer1;
   assign mem_wd_newer = clearing_ff ? '0 : px1_ff;

   // Line stores: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_older[mem_waddr] <= mem_wd_older;
         mem_newer[mem_waddr] <= mem_wd_newer;
      end
      if (accept) begin
         rdo_ff <= mem_older[c_b];
         rdn_ff <= mem_newer[c_b];
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         fwd_ff <= 1'b0;
      end else if (s1_free) begin
         v1_ff  <= accept;
         fwd_ff <= accept && s1_leave && (c1_ff == c_b);
      end
      if (accept) begin
         px1_ff   <= req_port.pixel;
         c1_ff    <= c_b;
         r1_ff    <= r_c;
         prod1_ff <= pos_produce;
         last1_ff <= pos_last;
         fwdo_ff  <= newer1;
         fwdn_ff  <= px1_ff;
      end
   end

   // Window: columns c-2 (entries 0..2) and c-1 (entries 3..5), rows r-2, r-1, r.
   logic signed [PIXEL_BITS-1:0] win_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) win_ff[k] <= '0;
      end else if (s1_leave) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= older1;
         win_ff[4] <= newer1;
         win_ff[5] <= px1_ff;
      end
   end

   // Sums of the four 2x2 sub-blocks of the 3x3 window.
   logic signed [SW-1:0] bs_in [4];
   always_comb begin
      bs_in[0] = SW'(win_ff[0]) + SW'(win_ff[1]) + SW'(win_ff[3]) + SW'(win_ff[4]);
      bs_in[1] = SW'(win_ff[3]) + SW'(win_ff[4]) + SW'(older1) + SW'(newer1);
      bs_in[2] = SW'(win_ff[1]) + SW'(win_ff[2]) + SW'(win_ff[4]) + SW'(win_ff[5]);
      bs_in[3] = SW'(win_ff[4]) + SW'(win_ff[5]) + SW'(newer1) + SW'(px1_ff);
   end

   // Output position, two rows and two columns back.
   logic [RW+PosW-1:0] orow_wide;
   logic [CW+PosW-1:0] ocol_wide;
   assign orow_wide = (RW+PosW)'(r1_ff) - (RW+PosW)'(2);
   assign ocol_wide = (CW+PosW)'(c1_ff) - (CW+PosW)'(2);

   // ---------------------------------------------------------------- stage 2
   logic signed [SW-1:0] bs2_ff [4];
   logic [PosW-1:0]      orow2_ff, ocol2_ff, orow3_ff, ocol3_ff;
   logic                 last2_ff, last3_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en2) v2_ff <= s1_leave && prod1_ff;
      if (en2 && s1_leave && prod1_ff) begin
         for (int k = 0; k < 4; k++) bs2_ff[k] <= bs_in[k];
         orow2_ff <= orow_wide[PosW-1:0];
         ocol2_ff <= ocol_wide[PosW-1:0];
         last2_ff <= last1_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic signed [PW-1:0] p3_ff [4];

   // One multiplier per kernel tap.
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en3) v3_ff <= v2_ff;
      if (en3 && v2_ff) begin
         for (int k = 0; k < 4; k++) p3_ff[k] <= PW'(tap_ff[k] * bs2_ff[k]);
         orow3_ff <= orow2_ff;
         ocol3_ff <= ocol2_ff;
         last3_ff <= last2_ff;
      end
   end

   // ---------------------------------------------------------------- output
   logic signed [AccW-1:0] acc_sum, acc_neg;
   logic signed [FW-1:0]   filt_ff;
   logic [PosW-1:0]        orow_ff, ocol_ff;
   logic                   olast_ff;

   assign acc_sum = AccW'(p3_ff[0]) + AccW'(p3_ff[1]) + AccW'(p3_ff[2]) + AccW'(p3_ff[3]);
   assign acc_neg = -acc_sum;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (en_out) ov_ff <= v3_ff;
      if (en_out && v3_ff) begin
         filt_ff  <= acc_neg[FW-1:0];
         orow_ff  <= orow3_ff;
         ocol_ff  <= ocol3_ff;
         olast_ff <= last3_ff;
      end
   end

   assign rsp_port.valid      = ov_ff;
   assign rsp_port.filtered   = filt_ff;
   assign rsp_port.out_row    = orow_ff;
   assign rsp_port.out_col    = ocol_ff;
   assign rsp_port.frame_last = olast_ff;

   // ---------------------------------------------------------------- checks
   // The pipeline holds nothing while the line stores are being cleared.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !(v1_ff || v2_ff || v3_ff || ov_ff))
      else $error("pipeline busy during line store clearing");

   // Forwarding is only armed by a pixel that left stage 1 on the previous edge.
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      $rose(fwd_ff) |-> $past(s1_leave))
      else $error("forwarding without a departing pixel");

   // A product stage item always comes from the block-sum stage.
   a_stage3_src: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !$past(v3_ff)) |-> $past(v2_ff))
      else $error("product stage loaded from an empty stage");

   // Stored column stays inside the line stores.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (CmpCW'(col_ff) < CmpCW'(MAX_COLS)))
      else $error("column counter beyond line store depth");

endmodule

FILE: dv/wkf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the 2-D window kernel filter: watches the pixel, result and register ports,
// predicts every filter output from its own copy of the state and compares field by field.
// Depends on wkf_pkg and on the channel interfaces in wkf_if.sv.

module wkf_checker (
   input  logic                                clock,
   input  logic                                reset,
   wkf_req_if                                  req_mon,
   wkf_rsp_if                                  rsp_mon,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic                                pready,
   input  logic [wkf_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [wkf_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output int                                  errors,
   output int                                  outstanding,
   output int                                  outputs_checked
);
   import wkf_pkg::*;

   localparam int COLS = DEF_MAX_COLS;
   localparam int ROWS = DEF_MAX_ROWS;
   localparam int PIX  = DEF_PIXEL_BITS;

   typedef struct packed {
      logic signed [FILTERED_BITS-1:0] filtered;
      logic [POS_BITS-1:0]             row;
      logic [POS_BITS-1:0]             col;
      logic                            last;
   } filter_out_type;

   // Shadow registers and the filter's own state.
   logic [SIZE_BITS-1:0]       width_reg;
   logic [SIZE_BITS-1:0]       height_reg;
   logic signed [TAP_BITS-1:0] taps [2][2];
   logic signed [PIX-1:0]      line_older [COLS];
   logic signed [PIX-1:0]      line_newer [COLS];
   logic signed [PIX-1:0]      win_left [3];
   logic signed [PIX-1:0]      win_mid [3];
   int unsigned                col_pos;
   int unsigned                row_pos;

   filter_out_type expected_q [$];
   int             fail_count = 0;
   int             checked_count = 0;

   assign errors          = fail_count;
   assign outputs_checked = checked_count;

   // The block clamps sizes into the range it supports.
   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   // Advance the raster position by one pixel and queue the filter output it completes.
   task automatic predict_pixel(input logic signed [PIX-1:0] px, input logic restart);
      int unsigned        w;
      int unsigned        h;
      int unsigned        r;
      int unsigned        c;
      logic signed [PIX-1:0] above2;
      logic signed [PIX-1:0] above1;
      longint             win [3][3];
      longint             acc;
      filter_out_type     want;
      w = clamp_dim(width_reg, COLS);
      h = clamp_dim(height_reg, ROWS);
      if (restart) begin
         col_pos = 0;
         row_pos = 0;
      end
      // A size shrunk under a held position wraps it.
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      above2 = line_older[c];
      above1 = line_newer[c];

      // Only windows fully inside the frame produce an output.
      if (r >= 2 && c >= 2) begin
         for (int k = 0; k < 3; k++) begin
            win[k][0] = win_left[k];
            win[k][1] = win_mid[k];
         end
         win[0][2] = above2;
         win[1][2] = above1;
         win[2][2] = px;
         acc = 0;
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
               acc += longint'(taps[i][j])
                      * (win[i][j] + win[i+1][j] + win[i][j+1] + win[i+1][j+1]);
         acc = -acc;
         want.filtered = acc[FILTERED_BITS-1:0];
         want.row      = POS_BITS'(r - 2);
         want.col      = POS_BITS'(c - 2);
         want.last     = (r == h - 1) && (c == w - 1);
         expected_q.push_back(want);
      end

      // Shift the window and update both line stores at this column.
      for (int k = 0; k < 3; k++) win_left[k] = win_mid[k];
      win_mid[0] = above2;
      win_mid[1] = above1;
      win_mid[2] = px;
      line_older[c] = above1;
      line_newer[c] = px;

      col_pos = c + 1;
      row_pos = r;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      filter_out_type want;
      if (reset) begin
         width_reg  = RST_WIDTH;
         height_reg = RST_HEIGHT;
         taps[0][0] = RST_TAP_TOP_LEFT;
         taps[0][1] = RST_TAP_TOP_RGHT;
         taps[1][0] = RST_TAP_BOT_LEFT;
         taps[1][1] = RST_TAP_BOT_RGHT;
         for (int i = 0; i < COLS; i++) begin
            line_older[i] = '0;
            line_newer[i] = '0;
         end
         for (int k = 0; k < 3; k++) begin
            win_left[k] = '0;
            win_mid[k]  = '0;
         end
         col_pos = 0;
         row_pos = 0;
         expected_q.delete();
      end else begin
         // Register write at the access phase; unused indexes change nothing.
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[CSR_ADDR_BITS-1:2]))
               REG_IMAGE_WIDTH:      width_reg  = pwdata[SIZE_BITS-1:0];
               REG_IMAGE_HEIGHT:     height_reg = pwdata[SIZE_BITS-1:0];
               REG_TAP_TOP_LEFT:     taps[0][0] = pwdata[TAP_BITS-1:0];
               REG_TAP_TOP_RIGHT:    taps[0][1] = pwdata[TAP_BITS-1:0];
               REG_TAP_BOTTOM_LEFT:  taps[1][0] = pwdata[TAP_BITS-1:0];
               REG_TAP_BOTTOM_RIGHT: taps[1][1] = pwdata[TAP_BITS-1:0];
               default: ;
            endcase
         end

         // Result transfer: compare with the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected output: row %0d col %0d filtered %0d",
                      rsp_mon.out_row, rsp_mon.out_col, rsp_mon.filtered);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               checked_count++;
               if (rsp_mon.filtered !== want.filtered) begin
                  $error("filtered: expected %0d, actual %0d", want.filtered, rsp_mon.filtered);
                  fail_count++;
               end
               if (rsp_mon.out_row !== want.row) begin
                  $error("out_row: expected %0d, actual %0d", want.row, rsp_mon.out_row);
                  fail_count++;
               end
               if (rsp_mon.out_col !== want.col) begin
                  $error("out_col: expected %0d, actual %0d", want.col, rsp_mon.out_col);
                  fail_count++;
               end
               if (rsp_mon.frame_last !== want.last) begin
                  $error("frame_last: expected %0d, actual %0d", want.last, rsp_mon.frame_last);
                  fail_count++;
               end
            end
         end

         // Pixel transfer.
         if (req_mon.valid && req_mon.ready)
            predict_pixel(req_mon.pixel, req_mon.frame_start);
      end
      outstanding <= expected_q.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the 2-D window kernel filter: clock, reset, pixel and register stimulus,
// result back-pressure, a stall watchdog and the verdict.
// Depends on wkf_pkg, wkf_if.sv, window_kernel_filter_2d_top and wkf_checker.

module testbench;
   import wkf_pkg::*;

   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_PIXELS  = 150;
   localparam int DEEP_ROWS     = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 4000;
   localparam logic [2:0] REG_SPARE = 3'd6;
   localparam logic signed [DEF_PIXEL_BITS-1:0] PIX_MIN = 16'sh8000;
   localparam logic signed [DEF_PIXEL_BITS-1:0] PIX_MAX = 16'sh7FFF;

   logic                       clock;
   logic                       reset;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [CSR_ADDR_BITS-1:0]   paddr;
   logic [CSR_DATA_BITS-1:0]   pwdata;
   logic [CSR_DATA_BITS-1:0]   prdata;
   logic                       pready;

   int          errors;
   int          outstanding;
   int          outputs_checked;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned pixels_sent = 0;
   int unsigned frames_sent = 0;
   int unsigned frame_cols;
   int unsigned frame_rows;

   wkf_req_if req_bus ();
   wkf_rsp_if rsp_bus ();

   window_kernel_filter_2d_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   wkf_checker filter_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .errors          (errors),
      .outstanding     (outstanding),
      .outputs_checked (outputs_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result back-pressure at the current idle rate.
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Ends the run when nothing has moved for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("No transfer for %0d cycles, giving up", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Register write: setup phase, then access phase, then an idle phase with psel low.
   task automatic write_csr(input logic [2:0] index, input logic [CSR_DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_taps(input logic signed [TAP_BITS-1:0] tl,
                             input logic signed [TAP_BITS-1:0] tr,
                             input logic signed [TAP_BITS-1:0] bl,
                             input logic signed [TAP_BITS-1:0] br);
      write_csr(REG_TAP_TOP_LEFT,     {16'($urandom), tl});
      write_csr(REG_TAP_TOP_RIGHT,    {16'($urandom), tr});
      write_csr(REG_TAP_BOTTOM_LEFT,  {16'($urandom), bl});
      write_csr(REG_TAP_BOTTOM_RIGHT, {16'($urandom), br});
   endtask

   // Sets the frame size; a size of 3 is sometimes written as an out-of-range value
   // below 3, which the block clamps back up.
   task automatic set_frame(input int unsigned cols, input int unsigned rows);
      logic [SIZE_BITS-1:0] cols_raw;
      logic [SIZE_BITS-1:0] rows_raw;
      cols_raw = SIZE_BITS'(cols);
      rows_raw = SIZE_BITS'(rows);
      if (cols == 3 && $urandom_range(1) == 1) cols_raw = SIZE_BITS'($urandom_range(2));
      if (rows == 3 && $urandom_range(1) == 1) rows_raw = SIZE_BITS'($urandom_range(2));
      write_csr(REG_IMAGE_WIDTH,  {21'($urandom), cols_raw});
      write_csr(REG_IMAGE_HEIGHT, {21'($urandom), rows_raw});
      frame_cols = cols;
      frame_rows = rows;
   endtask

   function automatic logic signed [DEF_PIXEL_BITS-1:0] pick_word();
      case ($urandom_range(7))
         0: return PIX_MIN;
         1: return PIX_MAX;
         2: return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_dim();
      case ($urandom_range(7))
         0: return 3;
         1: return $urandom_range(13, 24);
         default: return $urandom_range(3, 12);
      endcase
   endfunction

   // One pixel transfer, preceded by random idle cycles at the sender's rate.
   task automatic send_pixel(input logic signed [DEF_PIXEL_BITS-1:0] value,
                             input logic first);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.pixel       <= value;
      req_bus.frame_start <= first;
      do @(posedge clock); while (!req_bus.ready);
      pixels_sent++;
   endtask

   // Random pixels; a rare stray frame start in the middle acts as noise.
   task automatic send_frame(input int unsigned length, input bit with_start);
      for (int unsigned i = 0; i < length; i++)
         send_pixel(pick_word(), (with_start && i == 0) || $urandom_range(199) == 0);
      frames_sent++;
   endtask

   // Hold the input until every predicted output has arrived and the pipeline is empty.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned target;
      int unsigned kind;
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.pixel       <= '0;
      req_bus.frame_start <= 1'b0;
      req_idle_pct = 34;
      rsp_idle_pct = 83;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Smallest frame, most negative taps and pixels: the most negative output.
      // A write to an unused register index goes along and must change nothing.
      set_frame(3, 3);
      write_taps(PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN);
      write_csr(REG_SPARE, $urandom);
      for (int i = 0; i < 9; i++) send_pixel(PIX_MIN, i == 0);
      wait_for_results();

      // Largest pixels give the most positive output. No frame start: the position
      // wrapped by itself after the last frame. Stop at row 3, column 3.
      set_frame(4, 5);
      for (int i = 0; i < 15; i++) send_pixel(PIX_MAX, 1'b0);
      wait_for_results();

      // Shrinking the frame under the held position wraps both column and row.
      set_frame(3, 3);
      write_taps(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX);
      send_pixel(pick_word(), 1'b0);
      wait_for_results();

      // Random frames: mostly whole framed rasters, some cut short or unframed.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES / 3) begin
            req_idle_pct = 83;
            rsp_idle_pct = 34;
         end
         if (p == 2 * RANDOM_PHASES / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         set_frame(pick_dim(), pick_dim());
         write_taps(pick_word(), pick_word(), pick_word(), pick_word());
         target = pixels_sent + PHASE_PIXELS;
         while (pixels_sent < target) begin
            kind = $urandom_range(9);
            if (kind == 0)
               send_frame($urandom_range(frame_cols * frame_rows - 1, 1), 1'b1);
            else
               send_frame(frame_cols * frame_rows, kind != 1);
            if ($urandom_range(7) == 0) wait_for_results();
         end
         wait_for_results();
      end

      // A width written below range clamps to three columns and a height written past the
      // end clamps to the line store depth, so a deep partial frame runs without a wrap.
      write_csr(REG_IMAGE_WIDTH, '0);
      write_csr(REG_IMAGE_HEIGHT, 32'h0000_07FF);
      write_taps(pick_word(), pick_word(), pick_word(), pick_word());
      send_frame(3 * DEEP_ROWS, 1'b1);
      wait_for_results();

      $display("Covered %0d pixels in %0d frames, %0d filter outputs compared;",
               pixels_sent, frames_sent, outputs_checked);
      $display("sizes from 3x3 up to 24 wide, a clamped deep frame, extreme taps, three stall mixes.");
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
rtl/wkf_pkg.sv
rtl/wkf_if.sv
rtl/window_kernel_filter_2d_top.sv
dv/wkf_checker.sv
dv/testbench.sv
